FILE: design/assert_macros.svh
// Assertion macros shared by the Simon 32/64 RTL.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/simon_pkg.sv
// Types and constants for the Simon 32/64 bit-serial encryptor.
// No dependencies.
package simon_pkg;

	localparam int WORD_W  = 16;
	localparam int NROUNDS = 32;
	localparam int ZLEN    = 62;
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int RND_W   = $clog2(NROUNDS);
	localparam int ZIDX_W  = $clog2(ZLEN);

	localparam logic [WORD_W-1:0] ROUND_CONST = 16'hFFFC;
	// z0 sequence, leftmost digit (bit ZLEN-1) used first
	localparam logic [ZLEN-1:0]   ZSEQ        = 62'h3E8958737D12B0E6;

	typedef enum logic [1:0] {
		REG_KEY_WORD0 = 2'd0,
		REG_KEY_WORD1 = 2'd1,
		REG_KEY_WORD2 = 2'd2,
		REG_KEY_WORD3 = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [WORD_W-1:0] plain_left;
		logic [WORD_W-1:0] plain_right;
	} plain_t;

	typedef struct packed {
		logic [WORD_W-1:0] cipher_left;
		logic [WORD_W-1:0] cipher_right;
	} cipher_t;

	// control from the round sequencer to the key schedule
	typedef struct packed {
		logic load;   // take key words into the shift registers
		logic step;   // shift one bit
		logic last;   // last bit of the round: rotate word roles
		logic cbit;   // constant and z digit for this bit position
	} ks_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

FILE: design/simon_keysched.sv
// Bit-serial Simon 32/64 key schedule: four 16-bit shift registers.
// Depends on simon_pkg.
module simon_keysched (
	input  logic                                  clk,
	input  logic [3:0][simon_pkg::WORD_W-1:0]     key_word,
	input  simon_pkg::ks_ctrl_t                   ctrl,
	output logic                                  kbit
);

	// k0_q holds the key of the current round, k1_q..k3_q the next three. When
	// stepped, all rotate right one bit a cycle; k0_q takes in the key four rounds on.
	logic [simon_pkg::WORD_W-1:0] k0_q, k1_q, k2_q, k3_q;
	logic                         nbit;

	// bit j of k[i+4]: k[i] ^ t ^ (t >>> 1) ^ const ^ z, t = (k[i+3] >>> 3) ^ k[i+1]
	assign nbit = k0_q[0] ^ k3_q[3] ^ k3_q[4] ^ k1_q[0] ^ k1_q[1] ^ ctrl.cbit;
	assign kbit = k0_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			k0_q <= key_word[0];
			k1_q <= key_word[1];
			k2_q <= key_word[2];
			k3_q <= key_word[3];
		end else if (ctrl.step) begin
			if (ctrl.last) begin
				k0_q <= {k1_q[0], k1_q[simon_pkg::WORD_W-1:1]};
				k1_q <= {k2_q[0], k2_q[simon_pkg::WORD_W-1:1]};
				k2_q <= {k3_q[0], k3_q[simon_pkg::WORD_W-1:1]};
				k3_q <= {nbit, k0_q[simon_pkg::WORD_W-1:1]};
			end else begin
				k0_q <= {nbit, k0_q[simon_pkg::WORD_W-1:1]};
				k1_q <= {k1_q[0], k1_q[simon_pkg::WORD_W-1:1]};
				k2_q <= {k2_q[0], k2_q[simon_pkg::WORD_W-1:1]};
				k3_q <= {k3_q[0], k3_q[simon_pkg::WORD_W-1:1]};
			end
		end
	end

endmodule

FILE: design/simon32_64_block_encrypt.sv
// Simon 32/64 block encryptor, bit-serial round datapath and FSM.
// Depends on simon_pkg, simon_keysched and assert_macros.svh.

// A block is taken when start is high and busy is low, and encryption runs
// one bit of one round per cycle through the 16-bit shift registers of the
// Feistel halves and the key schedule, over 32 rounds, up to the edge that
// loads the result. done then pulses high for a single cycle, with the
// ciphertext on result; it must be taken then, as the next accepted block
// overwrites it. busy is already low in that cycle, so the next block may be
// started there. Key words are written through wr_en/wr_index/wr_data; the
// user must write them only while busy is low, as the block does not enforce it.
`include "assert_macros.svh"

module simon32_64_block_encrypt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  simon_pkg::plain_t             plain,
	output logic                          done,
	output simon_pkg::cipher_t            result,
	input  logic                          wr_en,
	input  simon_pkg::cfg_reg_t           wr_index,
	input  logic [simon_pkg::WORD_W-1:0]  wr_data
);

	localparam logic [simon_pkg::BIT_W-1:0] LAST_BIT = simon_pkg::BIT_W'(simon_pkg::WORD_W - 1);
	localparam logic [simon_pkg::RND_W-1:0] LAST_RND = simon_pkg::RND_W'(simon_pkg::NROUNDS - 1);

	simon_pkg::state_t state_q, state_d;
	logic [3:0][simon_pkg::WORD_W-1:0] key_q;
	logic [simon_pkg::WORD_W-1:0]      x_q, y_q;
	logic [simon_pkg::BIT_W-1:0]       bit_q;
	logic [simon_pkg::RND_W-1:0]       rnd_q;
	logic                              done_q;
	logic                              accept, step, last_bit, last_step;
	logic                              kbit, nbit, zbit;
	logic [simon_pkg::ZIDX_W-1:0]      z_idx;
	simon_pkg::ks_ctrl_t               ks_ctrl;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				simon_pkg::REG_KEY_WORD0: key_q[0] <= wr_data;
				simon_pkg::REG_KEY_WORD1: key_q[1] <= wr_data;
				simon_pkg::REG_KEY_WORD2: key_q[2] <= wr_data;
				simon_pkg::REG_KEY_WORD3: key_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= simon_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		step    = 1'b0;
		unique case (state_q)
			simon_pkg::ST_IDLE: begin
				if (start) begin
					state_d = simon_pkg::ST_RUN;
				end
			end
			simon_pkg::ST_RUN: begin
				busy = 1'b1;
				step = 1'b1;
				if (bit_q == LAST_BIT && rnd_q == LAST_RND) begin
					state_d = simon_pkg::ST_IDLE;
				end
			end
			default: state_d = simon_pkg::ST_IDLE;
		endcase
	end

	assign accept    = start && !busy;
	assign last_bit  = bit_q == LAST_BIT;
	assign last_step = step && last_bit && rnd_q == LAST_RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			rnd_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= last_step;
			if (accept) begin
				bit_q <= '0;
				rnd_q <= '0;
			end else if (step) begin
				bit_q <= bit_q + simon_pkg::BIT_W'(1);
				if (last_bit) begin
					rnd_q <= rnd_q + simon_pkg::RND_W'(1);
				end
			end
		end
	end

	// z digit for the key four rounds on; only enters at bit 0
	assign z_idx = simon_pkg::ZIDX_W'(simon_pkg::ZLEN - 1)
		- simon_pkg::ZIDX_W'(rnd_q);
	assign zbit  = simon_pkg::ZSEQ[z_idx];

	assign ks_ctrl.load = accept;
	assign ks_ctrl.step = step;
	assign ks_ctrl.last = last_bit;
	assign ks_ctrl.cbit = simon_pkg::ROUND_CONST[bit_q] ^ (zbit & (bit_q == '0));

	simon_keysched u_keysched (
		.clk      (clk),
		.key_word (key_q),
		.ctrl     (ks_ctrl),
		.kbit     (kbit)
	);

	// Stepping rotates x_q right once a cycle, so bit j-1 sits at the top, j-2 and
	// j-8 at 14 and 8. The new left bit goes into y_q; halves swap at round end.
	assign nbit = y_q[0] ^ (x_q[15] & x_q[8]) ^ x_q[14] ^ kbit;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= plain.plain_left;
			y_q <= plain.plain_right;
		end else if (step) begin
			if (last_bit) begin
				x_q <= {nbit, y_q[simon_pkg::WORD_W-1:1]};
				y_q <= {x_q[0], x_q[simon_pkg::WORD_W-1:1]};
			end else begin
				x_q <= {x_q[0], x_q[simon_pkg::WORD_W-1:1]};
				y_q <= {nbit, y_q[simon_pkg::WORD_W-1:1]};
			end
		end
	end

	assign done                = done_q;
	assign result.cipher_left  = x_q;
	assign result.cipher_right = y_q;

	`ASSERT_NEXT(a_start_runs, start && !busy, busy && bit_q == '0 && rnd_q == '0,
		"accepted block did not start at round zero")
	`ASSERT_NEXT(a_done_after_last, busy && bit_q == LAST_BIT && rnd_q == LAST_RND,
		done && !busy, "no done beat after the last round")
	`ASSERT_IMPL(a_done_idle, done, !busy && !$past(done), "done while running or held")
	`ASSERT_NEXT(a_round_holds, busy && bit_q != LAST_BIT, busy && $stable(rnd_q),
		"round count moved mid-round")

endmodule
